// ----- rtl/tte_pkg.sv -----
// Package for the Turing table depth-first enumerator.
// Holds the field widths and the rule entry type. It depends on nothing.
package tte_pkg;

	localparam int MaxStates = 8;
	localparam int SlotCnt   = 2 * MaxStates;
	localparam int StateW    = $clog2(MaxStates);
	localparam int SlotW     = $clog2(SlotCnt);
	localparam int CountW    = SlotW + 1;
	localparam int NumW      = 4;

	// Payload of one non-halt rule: symbol written, head direction, next state.
	typedef struct packed {
		logic              wr;
		logic              right;
		logic [StateW-1:0] nx;
	} rule_t;

endpackage

// ----- rtl/tte_channels.sv -----
// Handshake channels of the enumerator: input items, result items, register writes.
// Depends on tte_pkg for the field widths.
interface tte_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [tte_pkg::StateW-1:0] halt_state;
	logic                       halt_symbol;
	modport source (output valid, mode, halt_state, halt_symbol, input ready);
	modport sink (input valid, mode, halt_state, halt_symbol, output ready);
endinterface

interface tte_out_if;
	logic                       valid;
	logic                       ready;
	logic [tte_pkg::SlotW-1:0]  slot;
	logic                       is_halt;
	logic                       write_bit;
	logic                       move_right;
	logic [tte_pkg::StateW-1:0] next_state;
	logic                       last;
	logic                       done_res;
	modport source (output valid, slot, is_halt, write_bit, move_right, next_state, last,
		done_res, input ready);
	modport sink (input valid, slot, is_halt, write_bit, move_right, next_state, last,
		done_res, output ready);
endinterface

interface tte_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [tte_pkg::NumW-1:0] num_states;
	modport source (output valid, num_states, input ready);
	modport sink (input valid, num_states, output ready);
endinterface

// ----- rtl/turing_table_dfs_enumerator_core.sv -----
// Top level of the depth-first enumerator of two-symbol Turing machine tables.
// Depends on tte_pkg and the channel interfaces in tte_channels.sv.
//
//   channel  | dir | payload                                        | handshake
//   req_ch   | in  | mode, halt_state, halt_symbol                  | valid/ready
//   res_ch   | out | slot, is_halt, write_bit, move_right,          | valid/ready
//            |     | next_state, last, done_res                     |
//   cfg_ch   | in  | num_states                                     | valid/ready
//
// One sequencer steps a single scan unit. Each candidate tried is written in ADV,
// its stacked slots are scanned in SCAN and the table is judged in CHK; a push takes
// the place of the write step. Each result waits in the output register for ready,
// so a pop passes through ADV, OUT and LOAD, which reloads the candidate of the new
// top slot.
// The work an item takes is set by the number of rejected tries and pops.
// Reset and every num_states write restart the search.
// Each result waits in an output register until taken; no item is accepted meanwhile.
module turing_table_dfs_enumerator_core (
	input  logic         clk,
	input  logic         arst_n,
	tte_in_if.sink       req_ch,
	tte_out_if.source    res_ch,
	tte_cfg_if.sink      cfg_ch
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADV  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;

	localparam int SW = tte_pkg::SlotW;
	localparam int TW = tte_pkg::StateW;
	localparam int CW = tte_pkg::CountW;
	localparam int NW = tte_pkg::NumW;
	localparam int NS = tte_pkg::MaxStates;
	localparam int SC = tte_pkg::SlotCnt;

	logic [2:0]            state_q;
	logic [NW-1:0]         num_q;
	logic [SC-1:0]         halt_q;
	tte_pkg::rule_t        tab_q [SC];
	logic [SW-1:0]         stk_q [SC];
	logic [CW-1:0]         cnt_q;
	logic                  cw_q;
	logic                  cd_q;
	logic [TW-1:0]         cn_q;
	logic [SW-1:0]         idx_q;
	logic [NS-1:0]         used_q;
	logic                  any_q;
	logic [TW-1:0]         max_q;
	logic [SW-1:0]         o_slot_q;
	logic                  o_halt_q;
	logic                  o_wr_q;
	logic                  o_right_q;
	logic [TW-1:0]         o_nx_q;
	logic                  o_last_q;
	logic                  o_done_q;

	logic [NW-1:0]         n_eff;
	logic [TW-1:0]         nm1;
	logic [CW-1:0]         cnt_m1;
	logic [SW-1:0]         top;
	logic [SW-1:0]         push_slot;
	logic                  push_ok;
	logic                  cand_last;
	logic [SW-1:0]         scan_slot;
	tte_pkg::rule_t        scan_rule;
	logic                  scan_halt;
	logic                  accept_tab;
	logic                  gap;
	logic                  halt_reach;
	logic                  cfg_fire;
	logic                  in_fire;

	// Effective state count, clamped to 1..MaxStates.
	always_comb begin
		if (num_q == '0) begin
			n_eff = NW'(1);
		end else if (num_q > NW'(NS)) begin
			n_eff = NW'(NS);
		end else begin
			n_eff = num_q;
		end
	end
	assign nm1 = TW'(n_eff - NW'(1));

	// Stack top and push qualification.
	assign cnt_m1    = cnt_q - CW'(1);
	assign top       = stk_q[cnt_m1[SW-1:0]];
	assign push_slot = {req_ch.halt_state, req_ch.halt_symbol};
	assign push_ok   = !req_ch.mode && ({1'b0, req_ch.halt_state} < n_eff)
		&& ((cnt_q + CW'(1)) < {1'b0, n_eff} * CW'(2)) && halt_q[push_slot];
	assign cand_last = cw_q && cd_q && (cn_q == nm1);

	// Scan read port: one stack entry and its rule per cycle.
	assign scan_slot = stk_q[idx_q];
	assign scan_rule = tab_q[scan_slot];
	assign scan_halt = halt_q[scan_slot];

	// Table check from the gathered target set.
	always_comb begin
		gap        = 1'b0;
		halt_reach = 1'b0;
		for (int s = 1; s < NS; s++) begin
			if (any_q && (TW'(s) < max_q) && !used_q[s]) begin
				gap = 1'b1;
			end
			if (any_q && (TW'(s) <= max_q) && (halt_q[2*s] || halt_q[2*s+1])) begin
				halt_reach = 1'b1;
			end
		end
		if (halt_q[1] && used_q[0]) begin
			halt_reach = 1'b1;
		end
		accept_tab = !halt_q[0] && tab_q[0].right && !gap && halt_reach;
	end

	assign cfg_ch.ready = (state_q == ST_IDLE);
	assign req_ch.ready = (state_q == ST_IDLE) && !cfg_ch.valid;
	assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
	assign in_fire      = req_ch.valid && req_ch.ready;

	assign res_ch.valid      = (state_q == ST_OUT);
	assign res_ch.slot       = o_slot_q;
	assign res_ch.is_halt    = o_halt_q;
	assign res_ch.write_bit  = o_wr_q;
	assign res_ch.move_right = o_right_q;
	assign res_ch.next_state = o_nx_q;
	assign res_ch.last       = o_last_q;
	assign res_ch.done_res   = o_done_q;

	// Sequencer and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_q   <= NW'(2);
			halt_q  <= {{(SC-1){1'b1}}, 1'b0};
			for (int i = 0; i < SC; i++) begin
				tab_q[i] <= '0;
				stk_q[i] <= '0;
			end
			cnt_q     <= CW'(1);
			cw_q      <= 1'b0;
			cd_q      <= 1'b0;
			cn_q      <= '0;
			idx_q     <= '0;
			used_q    <= '0;
			any_q     <= 1'b0;
			max_q     <= '0;
			o_slot_q  <= '0;
			o_halt_q  <= 1'b0;
			o_wr_q    <= 1'b0;
			o_right_q <= 1'b0;
			o_nx_q    <= '0;
			o_last_q  <= 1'b0;
			o_done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						num_q  <= cfg_ch.num_states;
						halt_q <= {{(SC-1){1'b1}}, 1'b0};
						for (int i = 0; i < SC; i++) begin
							tab_q[i] <= '0;
							stk_q[i] <= '0;
						end
						cnt_q <= CW'(1);
						cw_q  <= 1'b0;
						cd_q  <= 1'b0;
						cn_q  <= '0;
					end else if (in_fire) begin
						if (cnt_q == '0) begin
							o_slot_q  <= '0;
							o_halt_q  <= 1'b1;
							o_wr_q    <= 1'b0;
							o_right_q <= 1'b1;
							o_nx_q    <= '0;
							o_last_q  <= 1'b1;
							o_done_q  <= 1'b1;
							state_q   <= ST_OUT;
						end else if (push_ok) begin
							stk_q[cnt_q[SW-1:0]] <= push_slot;
							cnt_q                <= cnt_q + CW'(1);
							halt_q[push_slot]    <= 1'b0;
							tab_q[push_slot]     <= '0;
							cw_q    <= 1'b0;
							cd_q    <= 1'b0;
							cn_q    <= '0;
							idx_q   <= '0;
							used_q  <= '0;
							any_q   <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_ADV: begin
					if (!cand_last) begin
						// Next candidate on the top slot.
						if (cn_q == nm1) begin
							cn_q         <= '0;
							{cw_q, cd_q} <= {cw_q, cd_q} + 2'd1;
							tab_q[top]   <= '{wr: cw_q ^ cd_q, right: !cd_q, nx: '0};
						end else begin
							cn_q       <= cn_q + TW'(1);
							tab_q[top] <= '{wr: cw_q, right: cd_q, nx: cn_q + TW'(1)};
						end
						idx_q   <= '0;
						used_q  <= '0;
						any_q   <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						// Exhausted: pop the top slot back to halt.
						cnt_q       <= cnt_m1;
						halt_q[top] <= 1'b1;
						o_slot_q    <= top;
						o_halt_q    <= 1'b1;
						o_wr_q      <= 1'b0;
						o_right_q   <= 1'b1;
						o_nx_q      <= '0;
						o_last_q    <= (cnt_m1 == '0);
						o_done_q    <= (cnt_m1 == '0);
						if (cnt_m1 == '0) begin
							cw_q <= 1'b0;
							cd_q <= 1'b0;
							cn_q <= '0;
						end
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					// Gather the targets of the stacked non-halt rules.
					if (!scan_halt) begin
						used_q[scan_rule.nx] <= 1'b1;
						any_q                <= 1'b1;
						if (!any_q || (scan_rule.nx > max_q)) begin
							max_q <= scan_rule.nx;
						end
					end
					idx_q <= idx_q + SW'(1);
					if (idx_q == cnt_m1[SW-1:0]) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (accept_tab) begin
						o_slot_q  <= top;
						o_halt_q  <= 1'b0;
						o_wr_q    <= cw_q;
						o_right_q <= cd_q;
						o_nx_q    <= cn_q;
						o_last_q  <= 1'b1;
						o_done_q  <= 1'b0;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_OUT: begin
					if (res_ch.ready) begin
						state_q <= o_last_q ? ST_IDLE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					// Resume the candidate held by the new top slot.
					cw_q    <= tab_q[top].wr;
					cd_q    <= tab_q[top].right;
					cn_q    <= tab_q[top].nx;
					state_q <= ST_ADV;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The stack never holds more slots than the table minus one.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(SC))
		else $error("stack count out of range");

	// An accepted item always starts work before the next one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("item accepted without work");

	// An exhausted search reports with an empty stack.
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.done_res) |-> (cnt_q == '0) && res_ch.last)
		else $error("done reported with a nonempty stack");

	// A pop that leaves slots on the stack is never the final result.
	a_pop_midway: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.is_halt && !res_ch.done_res) |-> !res_ch.last)
		else $error("intermediate pop marked last");

endmodule

// ----- dv/tte_checker.sv -----
// Checker for the Turing table enumerator: watches the request, result and register
// channels, predicts the slot updates and compares them. Depends on tte_pkg and tte_channels.
module tte_checker (
	input  logic    clk,
	input  logic    arst_n,
	tte_in_if       req_ch,
	tte_out_if      res_ch,
	tte_cfg_if      cfg_ch,
	output int      fail_count,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxStates = tte_pkg::MaxStates;
	localparam int SlotCnt   = tte_pkg::SlotCnt;
	localparam int SlotW     = tte_pkg::SlotW;
	localparam int StateW    = tte_pkg::StateW;
	localparam int NumW      = tte_pkg::NumW;

	typedef tte_pkg::rule_t rule_t;

	typedef struct packed {
		logic [SlotW-1:0]  slot;
		logic              is_halt;
		logic              write_bit;
		logic              move_right;
		logic [StateW-1:0] next_state;
		logic              last;
		logic              done_res;
	} update_t;

	// Shadow of the search: halt flag plus rule per slot.
	logic              tbl_halt [SlotCnt];
	rule_t             tbl_rule [SlotCnt];
	logic [SlotW-1:0]  filled [SlotCnt];
	int                depth;
	int                cand;
	logic [NumW-1:0]   n_reg;
	update_t           upd_q[$];

	function automatic int n_eff();
		if (n_reg < 1) return 1;
		if (n_reg > MaxStates) return MaxStates;
		return n_reg;
	endfunction

	function automatic rule_t cand_rule(int k, int n);
		rule_t r;
		r.wr = ((k / (2 * n)) % 2) != 0;
		r.right = ((k / n) % 2) != 0;
		r.nx = StateW'(k % n);
		return r;
	endfunction

	function automatic void restart_search();
		for (int i = 0; i < SlotCnt; i++) begin
			tbl_halt[i] = 1'b1;
			tbl_rule[i] = '0;
			filled[i] = '0;
		end
		tbl_halt[0] = 1'b0;
		tbl_rule[0] = cand_rule(0, n_eff());
		depth = 1;
		cand = 0;
	endfunction

	// Tree normal form: A0 moves right, targets dense from B, a halt reachable.
	function automatic bit table_ok(int n);
		bit used[MaxStates];
		int top_s;
		int nx;
		top_s = -1;
		foreach (used[i]) used[i] = 0;
		if (tbl_halt[0] || !tbl_rule[0].right) return 0;
		for (int i = 0; i < depth; i++) begin
			if (!tbl_halt[filled[i]]) begin
				nx = tbl_rule[filled[i]].nx % n;
				used[nx] = 1;
				if (nx > top_s) top_s = nx;
			end
		end
		for (int s = 1; s < top_s; s++)
			if (!used[s]) return 0;
		if (tbl_halt[1] && used[0]) return 1;
		for (int s = 1; s <= top_s; s++)
			if (tbl_halt[s*2] || tbl_halt[s*2+1]) return 1;
		return 0;
	endfunction

	// Append one expected update at the tail of the queue.
	function automatic void append_update(update_t u);
		upd_q.insert(upd_q.size(), u);
	endfunction

	function automatic void queue_update(int s, logic last, logic done);
		update_t u;
		u.slot = SlotW'(s);
		u.is_halt = tbl_halt[s];
		u.write_bit = tbl_halt[s] ? 1'b0 : tbl_rule[s].wr;
		u.move_right = tbl_halt[s] ? 1'b1 : tbl_rule[s].right;
		u.next_state = tbl_halt[s] ? '0 : tbl_rule[s].nx;
		u.last = last;
		u.done_res = done;
		append_update(u);
	endfunction

	function automatic void step_search(logic mode, logic [StateW-1:0] hs, logic hv);
		int n;
		int k;
		int s;
		rule_t r;
		update_t u;
		n = n_eff();
		k = cand;
		if (depth == 0) begin
			u = '{slot: '0, is_halt: 1'b1, write_bit: 1'b0, move_right: 1'b1,
				next_state: '0, last: 1'b1, done_res: 1'b1};
			append_update(u);
			return;
		end
		if (!mode && hs < n && depth + 1 < 2 * n) begin
			s = hs * 2 + hv;
			if (tbl_halt[s]) begin
				filled[depth] = SlotW'(s);
				depth++;
				tbl_halt[s] = 1'b0;
				tbl_rule[s] = cand_rule(0, n);
				k = 0;
				cand = 0;
				if (table_ok(n)) begin
					queue_update(s, 1'b1, 1'b0);
					return;
				end
			end
		end
		forever begin
			if (k + 1 < 4 * n) begin
				s = filled[depth-1];
				k++;
				cand = k;
				tbl_rule[s] = cand_rule(k, n);
				if (table_ok(n)) begin
					queue_update(s, 1'b1, 1'b0);
					return;
				end
			end else begin
				depth--;
				s = filled[depth];
				tbl_halt[s] = 1'b1;
				if (depth == 0) begin
					cand = 0;
					queue_update(s, 1'b1, 1'b1);
					return;
				end
				queue_update(s, 1'b0, 1'b0);
				r = tbl_rule[filled[depth-1]];
				k = r.wr * 2 * n + r.right * n + (r.nx % n);
				cand = k;
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Stage every handshake at the edge; results are checked before the next prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_reg = 4'd2;
			restart_search();
			upd_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (upd_q.size() == 0) begin
					$display("[%0t] result item with nothing expected", $realtime);
					fail_count++;
				end else begin
					update_t w;
					w = upd_q.pop_front();
					if (res_ch.slot != w.slot) report_mismatch("slot", res_ch.slot, w.slot);
					if (res_ch.is_halt != w.is_halt)
						report_mismatch("is_halt", res_ch.is_halt, w.is_halt);
					if (res_ch.write_bit != w.write_bit)
						report_mismatch("write_bit", res_ch.write_bit, w.write_bit);
					if (res_ch.move_right != w.move_right)
						report_mismatch("move_right", res_ch.move_right, w.move_right);
					if (res_ch.next_state != w.next_state)
						report_mismatch("next_state", res_ch.next_state, w.next_state);
					if (res_ch.last != w.last) report_mismatch("last", res_ch.last, w.last);
					if (res_ch.done_res != w.done_res)
						report_mismatch("done_res", res_ch.done_res, w.done_res);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				n_reg = cfg_ch.num_states;
				restart_search();
			end
			if (req_ch.valid && req_ch.ready)
				step_search(req_ch.mode, req_ch.halt_state, req_ch.halt_symbol);
			pending = upd_q.size();
		end
	end
endmodule

// ----- dv/turing_table_dfs_enumerator_core_tb.sv -----
// Top of the enumerator testbench: clock, reset, request and register stimulus, verdict.
// Depends on tte_pkg, tte_channels and the tte_checker module.
module turing_table_dfs_enumerator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StateW = tte_pkg::StateW;
	localparam int NumW   = tte_pkg::NumW;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle;
	int   sink_stall;
	int   fill_pct;

	tte_in_if  req_ch ();
	tte_out_if res_ch ();
	tte_cfg_if cfg_ch ();

	turing_table_dfs_enumerator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch.sink),
		.res_ch (res_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	tte_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_ch     (req_ch),
		.res_ch     (res_ch),
		.cfg_ch     (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Result sink stalls at the rate of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// Drive one request item and hold it until accepted. The block is busy right after
	// an accepted item, so the task idles before it returns.
	task automatic send_item(logic mode, logic [StateW-1:0] hs, logic hv);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.halt_state <= hs;
		req_ch.halt_symbol <= hv;
		do @(posedge clk); while (!req_ch.ready);
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Let the block settle before touching its register.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_num_states(logic [NumW-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.num_states <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Halts within the used states in fill_pct percent of items, so the search goes deep.
	task automatic random_items(int cnt, int n);
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(99) < fill_pct)
				send_item(1'b0, StateW'($urandom_range(n - 1)), 1'($urandom_range(1)));
			else
				send_item(1'($urandom_range(1)), StateW'($urandom_range(7)),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = 1'b0;
		req_ch.halt_state = '0;
		req_ch.halt_symbol = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.num_states = '0;
		send_idle = 0;
		sink_stall = 0;
		fill_pct = 80;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting, halts at extremes, out-of-range state, filled slot.
		send_item(1'b0, 3'd1, 1'b0);
		send_item(1'b0, 3'd1, 1'b0);
		send_item(1'b0, 3'd7, 1'b1);
		send_item(1'b0, 3'd0, 1'b1);
		send_item(1'b1, 3'd0, 1'b0);
		send_item(1'b0, 3'd1, 1'b1);
		// One state: the search exhausts quickly, then inputs after exhaustion.
		write_num_states(4'd1);
		for (int i = 0; i < 8; i++) send_item(1'($urandom_range(1)), 3'd0, 1'b0);
		// Clamped register values at both ends.
		write_num_states(4'd0);
		send_item(1'b1, 3'd0, 1'b0);
		send_item(1'b1, 3'd0, 1'b0);
		write_num_states(4'd15);
		send_item(1'b0, 3'd7, 1'b1);
		send_item(1'b0, 3'd6, 1'b0);
		send_item(1'b1, 3'd5, 1'b1);
		write_num_states(4'd8);
		send_item(1'b0, 3'd2, 1'b1);
		send_item(1'b1, 3'd0, 1'b0);

		// Random phases: none, sender idle, receiver stall, both.
		write_num_states(4'd2);
		random_items(70, 2);
		send_idle = 48;
		write_num_states(4'd3);
		random_items(70, 3);
		send_idle = 0;
		sink_stall = 48;
		write_num_states(4'd4);
		random_items(70, 4);
		// Pause until every expected update has arrived.
		while (pending != 0) @(posedge clk);
		send_idle = 7;
		sink_stall = 7;
		write_num_states(4'd8);
		random_items(60, 8);
		send_idle = 0;
		sink_stall = 0;
		fill_pct = 50;
		write_num_states(4'd1);
		random_items(20, 1);
		write_num_states(4'd2);
		random_items(60, 2);

		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#500ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
